// ===== rtl/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared widths, codes and configuration type for the height map sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int POS_W      = 32;
    localparam int TPU_W      = 32;
    localparam int SIZE_W     = 9;
    localparam int HEIGHT_W   = 16;
    localparam int ADDR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_TPU_X      = 2'd2,
        CFG_TPU_Z      = 2'd3
    } t_cfg_idx;

    localparam logic [SIZE_W-1:0] MAP_SIZE_RST = 9'd256;
    localparam logic [TPU_W-1:0]  TPU_RST      = 32'h0001_0000;

    typedef struct packed {
        logic [SIZE_W-1:0] map_width;
        logic [SIZE_W-1:0] map_height;
        logic [TPU_W-1:0]  tpu_x;
        logic [TPU_W-1:0]  tpu_z;
    } t_cfg;

endpackage

// ===== rtl/hbs_fifo.sv =====
// ----------------------------------------------------------------------------
// hbs_fifo
// Small synchronous queue; decouples the front and back ends and holds results.
// ----------------------------------------------------------------------------
module hbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not follow a lone transfer in");
`endif

endmodule

// ===== rtl/hbs_front.sv =====
// ----------------------------------------------------------------------------
// hbs_front
// Takes items, drops out-of-range writes, maps sample positions to clamped
// map coordinates through a four-stage pipeline.
// ----------------------------------------------------------------------------
module hbs_front
    import hbs_pkg::*;
#(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 8,
    localparam int SIDE_W       = $clog2(MAX_SIDE)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_mode,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [ADDR_W-1:0]        i_write_col,
    input  logic [ADDR_W-1:0]        i_write_row,
    input  logic [HEIGHT_W-1:0]      i_write_height,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_is_write,
    output logic [ADDR_W-1:0]        o_col,
    output logic [ADDR_W-1:0]        o_row,
    output logic [HEIGHT_W-1:0]      o_wdata,
    output logic [SIDE_W-1:0]        o_ix,
    output logic [SIDE_W-1:0]        o_iz,
    output logic [FRACTION_BITS-1:0] o_fx,
    output logic [FRACTION_BITS-1:0] o_fz
);

    localparam int SZ_W   = $clog2(MAX_SIDE + 1);
    localparam int CW     = SIDE_W + FRACTION_BITS;
    localparam int SH     = POS_W - FRACTION_BITS;
    localparam int PROD_W = POS_W + TPU_W;
    localparam int MAG_W  = POS_W + FRACTION_BITS;
    localparam int CV_W   = MAG_W + 2;
    localparam logic [PROD_W-1:0] RND_BIAS = (PROD_W'(1) << SH) - PROD_W'(1);

    function automatic logic [SZ_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        priority if (s < SIZE_W'(2)) begin
            eff_size = SZ_W'(2);
        end else if (32'(s) > 32'(MAX_SIDE)) begin
            eff_size = SZ_W'(MAX_SIDE);
        end else begin
            eff_size = SZ_W'(s);
        end
    endfunction

    function automatic logic [CW-1:0] clamp_coord(input logic signed [CV_W-1:0] c,
                                                  input logic signed [CV_W-1:0] lim,
                                                  input logic [CW-1:0] top);
        priority if (c >= lim) begin
            clamp_coord = top;
        end else if (c[CV_W-1]) begin
            clamp_coord = '0;
        end else begin
            clamp_coord = CW'(c);
        end
    endfunction

    logic [SZ_W-1:0]        w_size_x, w_size_z;
    logic signed [CV_W-1:0] w_off_x, w_off_z;
    logic signed [CV_W-1:0] w_lim_x, w_lim_z;
    logic [CW-1:0]          w_top_x, w_top_z;
    logic [POS_W-1:0]       w_mag_x, w_mag_z;
    logic                   w_keep;
    logic                   w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;
    logic signed [CV_W-1:0] w_cx, w_cz;
    logic [CW-1:0]          n_coord_x, n_coord_z;

    logic                   r_a_valid, r_a_write, r_a_neg_x, r_a_neg_z;
    logic [POS_W-1:0]       r_a_mag_x, r_a_mag_z;
    logic [ADDR_W-1:0]      r_a_col, r_a_row;
    logic [HEIGHT_W-1:0]    r_a_wdata;

    logic                   r_b_valid, r_b_write, r_b_neg_x, r_b_neg_z;
    logic [PROD_W-1:0]      r_b_prod_x, r_b_prod_z;
    logic [ADDR_W-1:0]      r_b_col, r_b_row;
    logic [HEIGHT_W-1:0]    r_b_wdata;

    logic                   r_c_valid, r_c_write, r_c_neg_x, r_c_neg_z;
    logic [MAG_W-1:0]       r_c_mag_x, r_c_mag_z;
    logic [ADDR_W-1:0]      r_c_col, r_c_row;
    logic [HEIGHT_W-1:0]    r_c_wdata;

    logic                   r_d_valid, r_d_write;
    logic [CW-1:0]          r_d_coord_x, r_d_coord_z;
    logic [ADDR_W-1:0]      r_d_col, r_d_row;
    logic [HEIGHT_W-1:0]    r_d_wdata;

    assign w_size_x = eff_size(i_cfg.map_width);
    assign w_size_z = eff_size(i_cfg.map_height);
    assign w_off_x  = (CV_W'(w_size_x) + CV_W'(1)) << (FRACTION_BITS - 1);
    assign w_off_z  = (CV_W'(w_size_z) + CV_W'(1)) << (FRACTION_BITS - 1);
    assign w_lim_x  = CV_W'(w_size_x - SZ_W'(1)) << FRACTION_BITS;
    assign w_lim_z  = CV_W'(w_size_z - SZ_W'(1)) << FRACTION_BITS;
    assign w_top_x  = CW'(CV_W'(w_size_x - SZ_W'(2)) << FRACTION_BITS);
    assign w_top_z  = CW'(CV_W'(w_size_z - SZ_W'(2)) << FRACTION_BITS);

    assign w_mag_x = i_pos_x[POS_W-1] ? (POS_W'(0) - unsigned'(i_pos_x)) : unsigned'(i_pos_x);
    assign w_mag_z = i_pos_z[POS_W-1] ? (POS_W'(0) - unsigned'(i_pos_z)) : unsigned'(i_pos_z);

    // writes with a column or row at or beyond MAX_SIDE are dropped here
    assign w_keep = (i_mode == MODE_SAMPLE)
                 || ((32'(i_write_col) < 32'(MAX_SIDE)) && (32'(i_write_row) < 32'(MAX_SIDE)));

    assign w_rdy_d = !r_d_valid || i_ready;
    assign w_rdy_c = !r_c_valid || w_rdy_d;
    assign w_rdy_b = !r_b_valid || w_rdy_c;
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_ready = w_rdy_a;

    assign w_cx = r_c_neg_x ? (w_off_x - CV_W'(r_c_mag_x)) : (w_off_x + CV_W'(r_c_mag_x));
    assign w_cz = r_c_neg_z ? (w_off_z - CV_W'(r_c_mag_z)) : (w_off_z + CV_W'(r_c_mag_z));
    assign n_coord_x = clamp_coord(w_cx, w_lim_x, w_top_x);
    assign n_coord_z = clamp_coord(w_cz, w_lim_z, w_top_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_valid <= i_valid && w_keep;
            end
            if (w_rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (w_rdy_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_write <= (i_mode == MODE_WRITE);
            r_a_neg_x <= i_pos_x[POS_W-1];
            r_a_neg_z <= i_pos_z[POS_W-1];
            r_a_mag_x <= w_mag_x;
            r_a_mag_z <= w_mag_z;
            r_a_col   <= i_write_col;
            r_a_row   <= i_write_row;
            r_a_wdata <= i_write_height;
        end
        if (w_rdy_b) begin
            r_b_write  <= r_a_write;
            r_b_neg_x  <= r_a_neg_x;
            r_b_neg_z  <= r_a_neg_z;
            r_b_prod_x <= PROD_W'(r_a_mag_x) * PROD_W'(i_cfg.tpu_x);
            r_b_prod_z <= PROD_W'(r_a_mag_z) * PROD_W'(i_cfg.tpu_z);
            r_b_col    <= r_a_col;
            r_b_row    <= r_a_row;
            r_b_wdata  <= r_a_wdata;
        end
        if (w_rdy_c) begin
            r_c_write <= r_b_write;
            r_c_neg_x <= r_b_neg_x;
            r_c_neg_z <= r_b_neg_z;
            // negative side rounds up in magnitude: floor of the signed value
            r_c_mag_x <= MAG_W'((r_b_prod_x + (r_b_neg_x ? RND_BIAS : '0)) >> SH);
            r_c_mag_z <= MAG_W'((r_b_prod_z + (r_b_neg_z ? RND_BIAS : '0)) >> SH);
            r_c_col   <= r_b_col;
            r_c_row   <= r_b_row;
            r_c_wdata <= r_b_wdata;
        end
        if (w_rdy_d) begin
            r_d_write   <= r_c_write;
            r_d_coord_x <= n_coord_x;
            r_d_coord_z <= n_coord_z;
            r_d_col     <= r_c_col;
            r_d_row     <= r_c_row;
            r_d_wdata   <= r_c_wdata;
        end
    end

    assign o_valid    = r_d_valid;
    assign o_is_write = r_d_write;
    assign o_col      = r_d_col;
    assign o_row      = r_d_row;
    assign o_wdata    = r_d_wdata;
    assign o_ix       = r_d_coord_x[CW-1:FRACTION_BITS];
    assign o_iz       = r_d_coord_z[CW-1:FRACTION_BITS];
    assign o_fx       = r_d_coord_x[FRACTION_BITS-1:0];
    assign o_fz       = r_d_coord_z[FRACTION_BITS-1:0];

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !w_rdy_d) |=> (r_c_valid && $stable(r_c_mag_x) && $stable(r_c_mag_z)))
        else $error("rounding stage lost its item under stall");
`endif

endmodule

// ===== rtl/hbs_back.sv =====
// ----------------------------------------------------------------------------
// hbs_back
// Four row/column parity banks of height samples; stores writes, reads the
// four neighbours of a sample in parallel and lerps along x then z.
// ----------------------------------------------------------------------------
module hbs_back
    import hbs_pkg::*;
#(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 8,
    localparam int SIDE_W       = $clog2(MAX_SIDE)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_is_write,
    input  logic [ADDR_W-1:0]        i_col,
    input  logic [ADDR_W-1:0]        i_row,
    input  logic [HEIGHT_W-1:0]      i_wdata,
    input  logic [SIDE_W-1:0]        i_ix,
    input  logic [SIDE_W-1:0]        i_iz,
    input  logic [FRACTION_BITS-1:0] i_fx,
    input  logic [FRACTION_BITS-1:0] i_fz,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [HEIGHT_W-1:0]      o_height
);

    localparam int HALF_W     = (SIDE_W > 1) ? SIDE_W - 1 : 1;
    localparam int BANK_AW    = 2 * HALF_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int ACC_W      = HEIGHT_W + FRACTION_BITS + 1;
    localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

    function automatic logic [HEIGHT_W-1:0] lerp(input logic [HEIGHT_W-1:0] a,
                                                 input logic [HEIGHT_W-1:0] b,
                                                 input logic [FRACTION_BITS-1:0] f);
        logic [FRACTION_BITS:0] wa;
        logic [ACC_W-1:0]       acc;
        wa   = ONE - (FRACTION_BITS + 1)'(f);
        acc  = ACC_W'(a) * ACC_W'(wa) + ACC_W'(b) * ACC_W'(f);
        lerp = HEIGHT_W'(acc >> FRACTION_BITS);
    endfunction

    logic                     w_take;
    logic                     w_rdy_1, w_rdy_2;
    logic [SIDE_W-1:0]        w_wcol, w_wrow;
    logic [1:0]               w_wbank;
    logic [BANK_AW-1:0]       w_waddr;
    logic [HALF_W-1:0]        w_ex, w_ox, w_ez, w_oz;
    logic [HEIGHT_W-1:0]      w_lo_c0, w_lo_c1, w_hi_c0, w_hi_c1;
    logic [HEIGHT_W-1:0]      w_v1, w_v2, w_v3, w_v4;

    logic [HEIGHT_W-1:0]      r_rdata [4];
    logic                     r_1_valid, r_1_px, r_1_pz;
    logic [FRACTION_BITS-1:0] r_1_fx, r_1_fz;
    logic                     r_2_valid;
    logic [HEIGHT_W-1:0]      r_2_i1, r_2_i2;
    logic [FRACTION_BITS-1:0] r_2_fz;

    assign w_rdy_2 = !r_2_valid || i_ready;
    assign w_rdy_1 = !r_1_valid || w_rdy_2;
    assign o_ready = w_rdy_1;
    assign w_take  = i_valid && w_rdy_1;

    assign w_wcol  = SIDE_W'(i_col);
    assign w_wrow  = SIDE_W'(i_row);
    assign w_wbank = {w_wrow[0], w_wcol[0]};
    assign w_waddr = {HALF_W'(w_wrow >> 1), HALF_W'(w_wcol >> 1)};

    // even-parity bank holds ix or ix+1, whichever is even
    assign w_ex = HALF_W'(({1'b0, i_ix} + (SIDE_W + 1)'(1)) >> 1);
    assign w_ox = HALF_W'(i_ix >> 1);
    assign w_ez = HALF_W'(({1'b0, i_iz} + (SIDE_W + 1)'(1)) >> 1);
    assign w_oz = HALF_W'(i_iz >> 1);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [HEIGHT_W-1:0] r_mem [BANK_DEPTH];
        logic [BANK_AW-1:0]  w_raddr;

        assign w_raddr = {((b & 2) != 0) ? w_oz : w_ez, ((b & 1) != 0) ? w_ox : w_ex};

        always_ff @(posedge i_clk) begin
            if (w_take && i_is_write && (w_wbank == 2'(b))) begin
                r_mem[w_waddr] <= i_wdata;
            end
            if (w_rdy_1) begin
                r_rdata[b] <= r_mem[w_raddr];
            end
        end
    end

    assign w_lo_c0 = r_1_pz ? r_rdata[2] : r_rdata[0];
    assign w_lo_c1 = r_1_pz ? r_rdata[3] : r_rdata[1];
    assign w_hi_c0 = r_1_pz ? r_rdata[0] : r_rdata[2];
    assign w_hi_c1 = r_1_pz ? r_rdata[1] : r_rdata[3];
    assign w_v1    = r_1_px ? w_lo_c1 : w_lo_c0;
    assign w_v2    = r_1_px ? w_lo_c0 : w_lo_c1;
    assign w_v3    = r_1_px ? w_hi_c1 : w_hi_c0;
    assign w_v4    = r_1_px ? w_hi_c0 : w_hi_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_valid <= 1'b0;
            r_2_valid <= 1'b0;
        end else begin
            if (w_rdy_1) begin
                r_1_valid <= w_take && !i_is_write;
            end
            if (w_rdy_2) begin
                r_2_valid <= r_1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_1) begin
            r_1_px <= i_ix[0];
            r_1_pz <= i_iz[0];
            r_1_fx <= i_fx;
            r_1_fz <= i_fz;
        end
        if (w_rdy_2) begin
            r_2_i1 <= lerp(w_v1, w_v2, r_1_fx);
            r_2_i2 <= lerp(w_v3, w_v4, r_1_fx);
            r_2_fz <= r_1_fz;
        end
    end

    assign o_valid  = r_2_valid;
    assign o_height = lerp(r_2_i1, r_2_i2, r_2_fz);

`ifndef ASSERT_OFF
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_is_write) |=> !r_1_valid)
        else $error("write command raised a result");

    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_1_valid && !w_rdy_2) |=> (r_1_valid && $stable(r_rdata[0]) && $stable(r_1_fx)))
        else $error("bank read data changed under stall");
`endif

endmodule

// ===== rtl/heightmap_bilinear_sampler_core.sv =====
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_core: height map store with bilinear sampling
// Throughput: one item per cycle unless the result queue backs up, held by the
// pipelined 32x32 multipliers and one read or write per cycle on each of the
// four parity banks.
// Reset: control and settings to defaults; height store keeps old contents.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_core
    import hbs_pkg::*;
#(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_mode,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic [ADDR_W-1:0]       i_write_col,
    input  logic [ADDR_W-1:0]       i_write_row,
    input  logic [HEIGHT_W-1:0]     i_write_height,
    output logic                    empty,
    input  logic                    pop,
    output logic [HEIGHT_W-1:0]     o_height
);

    localparam int SIDE_W = $clog2(MAX_SIDE);

    typedef struct packed {
        logic                     is_write;
        logic [ADDR_W-1:0]        col;
        logic [ADDR_W-1:0]        row;
        logic [HEIGHT_W-1:0]      wdata;
        logic [SIDE_W-1:0]        ix;
        logic [SIDE_W-1:0]        iz;
        logic [FRACTION_BITS-1:0] fx;
        logic [FRACTION_BITS-1:0] fz;
    } t_cmd;

    t_cfg                r_cfg;
    t_cmd                w_front_cmd;
    t_cmd                w_back_cmd;
    logic                w_front_ready;
    logic                w_front_valid;
    logic                w_cmd_full;
    logic                w_cmd_empty;
    logic                w_back_ready;
    logic                w_res_valid;
    logic                w_res_full;
    logic [HEIGHT_W-1:0] w_res_height;

    assign o_cfg_ready = 1'b1;
    assign full        = !w_front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width  <= MAP_SIZE_RST;
            r_cfg.map_height <= MAP_SIZE_RST;
            r_cfg.tpu_x      <= TPU_RST;
            r_cfg.tpu_z      <= TPU_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAP_WIDTH:  r_cfg.map_width  <= SIZE_W'(i_cfg_data);
                CFG_MAP_HEIGHT: r_cfg.map_height <= SIZE_W'(i_cfg_data);
                CFG_TPU_X:      r_cfg.tpu_x      <= TPU_W'(i_cfg_data);
                CFG_TPU_Z:      r_cfg.tpu_z      <= TPU_W'(i_cfg_data);
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    hbs_front #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (push),
        .o_ready        (w_front_ready),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_z        (i_pos_z),
        .i_write_col    (i_write_col),
        .i_write_row    (i_write_row),
        .i_write_height (i_write_height),
        .o_valid        (w_front_valid),
        .i_ready        (!w_cmd_full),
        .o_is_write     (w_front_cmd.is_write),
        .o_col          (w_front_cmd.col),
        .o_row          (w_front_cmd.row),
        .o_wdata        (w_front_cmd.wdata),
        .o_ix           (w_front_cmd.ix),
        .o_iz           (w_front_cmd.iz),
        .o_fx           (w_front_cmd.fx),
        .o_fz           (w_front_cmd.fz)
    );

    hbs_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (4)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_cmd),
        .o_full  (w_cmd_full),
        .i_pop   (w_back_ready),
        .o_data  (w_back_cmd),
        .o_empty (w_cmd_empty)
    );

    hbs_back #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_cmd_empty),
        .o_ready    (w_back_ready),
        .i_is_write (w_back_cmd.is_write),
        .i_col      (w_back_cmd.col),
        .i_row      (w_back_cmd.row),
        .i_wdata    (w_back_cmd.wdata),
        .i_ix       (w_back_cmd.ix),
        .i_iz       (w_back_cmd.iz),
        .i_fx       (w_back_cmd.fx),
        .i_fz       (w_back_cmd.fz),
        .o_valid    (w_res_valid),
        .i_ready    (!w_res_full),
        .o_height   (w_res_height)
    );

    hbs_fifo #(
        .WIDTH (HEIGHT_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res_height),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_height),
        .o_empty (empty)
    );

endmodule

// ===== test/heightmap_bilinear_sampler_core_checker.sv =====
// ----------------------------------------------------------------------------
// Height map sampler checker
// Watches the configuration, input and result channels of the sampler core.
// It keeps its own height store and settings, predicts the interpolated
// height of every accepted sample and compares each popped result in order.
// ----------------------------------------------------------------------------
package hbs_test_pkg;

    import hbs_pkg::*;

    localparam int GRID_SIDE = 256;
    localparam int FRAC_BITS = 8;

    function automatic int unsigned eff_side(logic [SIZE_W-1:0] s);
        if (s < 2) return 2;
        if (s > GRID_SIDE) return GRID_SIDE;
        return s;
    endfunction

    // Q16.16 position to clamped map coordinate with FRAC_BITS of fraction
    function automatic logic [31:0] grid_coord(logic [31:0] pos, logic [31:0] tpu,
                                               int unsigned side);
        logic [31:0] mag;
        logic [63:0] prod;
        longint      c;
        longint      limit_c;
        mag  = pos[31] ? (~pos + 32'd1) : pos;
        prod = {32'd0, mag} * {32'd0, tpu};
        if (pos[31])
            c = -longint'((prod + ((64'd1 << (32 - FRAC_BITS)) - 64'd1)) >> (32 - FRAC_BITS));
        else
            c = longint'(prod >> (32 - FRAC_BITS));
        c       = c + (longint'(side + 1) << (FRAC_BITS - 1));
        limit_c = longint'(side - 1) << FRAC_BITS;
        if (c >= limit_c) c = longint'(side - 2) << FRAC_BITS;
        if (c < 0) c = 0;
        return 32'(c);
    endfunction

endpackage

module heightmap_bilinear_sampler_core_checker
    import hbs_pkg::*, hbs_test_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic                  i_mode,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_z,
    input  logic [ADDR_W-1:0]     i_write_col,
    input  logic [ADDR_W-1:0]     i_write_row,
    input  logic [HEIGHT_W-1:0]   i_write_height,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic [HEIGHT_W-1:0]   i_height,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [HEIGHT_W-1:0] height_mem [GRID_SIDE*GRID_SIDE];
    logic [HEIGHT_W-1:0] height_due_q [$];
    logic [HEIGHT_W-1:0] oldest_height;
    logic [SIZE_W-1:0]   map_w;
    logic [SIZE_W-1:0]   map_h;
    logic [TPU_W-1:0]    tpu_x;
    logic [TPU_W-1:0]    tpu_z;
    int                  fail_total = 0;

    task automatic report_mismatch(string what);
        if (fail_total < 100) $display("%0t: height check: %s", $time, what);
        fail_total++;
    endtask

    function automatic logic [HEIGHT_W-1:0] blend(logic [HEIGHT_W-1:0] a,
                                                  logic [HEIGHT_W-1:0] b,
                                                  logic [FRAC_BITS-1:0] f);
        logic [31:0] acc;
        acc = 32'(a) * ((32'd1 << FRAC_BITS) - 32'(f)) + 32'(b) * 32'(f);
        return HEIGHT_W'(acc >> FRAC_BITS);
    endfunction

    function automatic logic [HEIGHT_W-1:0] predict_height(logic [31:0] px, logic [31:0] pz);
        logic [31:0]          cx;
        logic [31:0]          cz;
        int unsigned          ix;
        int unsigned          iz;
        logic [HEIGHT_W-1:0]  near_row;
        logic [HEIGHT_W-1:0]  far_row;
        cx = grid_coord(px, tpu_x, eff_side(map_w));
        cz = grid_coord(pz, tpu_z, eff_side(map_h));
        ix = cx >> FRAC_BITS;
        iz = cz >> FRAC_BITS;
        near_row = blend(height_mem[iz*GRID_SIDE + ix], height_mem[iz*GRID_SIDE + ix + 1],
                         cx[FRAC_BITS-1:0]);
        far_row  = blend(height_mem[(iz+1)*GRID_SIDE + ix],
                         height_mem[(iz+1)*GRID_SIDE + ix + 1], cx[FRAC_BITS-1:0]);
        return blend(near_row, far_row, cz[FRAC_BITS-1:0]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            map_w = MAP_SIZE_RST;
            map_h = MAP_SIZE_RST;
            tpu_x = TPU_RST;
            tpu_z = TPU_RST;
            height_due_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (height_due_q.size() == 0) begin
                    report_mismatch($sformatf("height %h popped with no sample waiting",
                                              i_height));
                end else begin
                    oldest_height = height_due_q.pop_front();
                    if (i_height !== oldest_height)
                        report_mismatch($sformatf("expected %h, got %h",
                                                  oldest_height, i_height));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MAP_WIDTH:  map_w = i_cfg_data[SIZE_W-1:0];
                    CFG_MAP_HEIGHT: map_h = i_cfg_data[SIZE_W-1:0];
                    CFG_TPU_X:      tpu_x = i_cfg_data;
                    CFG_TPU_Z:      tpu_z = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                if (i_mode == MODE_WRITE)
                    height_mem[i_write_row*GRID_SIDE + i_write_col] = i_write_height;
                else
                    height_due_q.push_back(predict_height(i_pos_x, i_pos_z));
            end
        end
        o_pending    <= height_due_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== test/heightmap_bilinear_sampler_core_test.sv =====
// ----------------------------------------------------------------------------
// Height map sampler core testbench
// Writes height samples and queries positions across several map sizes and
// scales, directed corner cases first, then random traffic, mostly with random
// gaps on both sides. Only fully written neighbourhoods are ever sampled.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hbs_pkg::*;
    import hbs_test_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_ITEMS   = 200;
    localparam int PHASE_COUNT   = 6;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  push           = 1'b0;
    logic                  full;
    logic                  mode           = MODE_WRITE;
    logic [POS_W-1:0]      pos_x          = '0;
    logic [POS_W-1:0]      pos_z          = '0;
    logic [ADDR_W-1:0]     write_col      = '0;
    logic [ADDR_W-1:0]     write_row      = '0;
    logic [HEIGHT_W-1:0]   write_height   = '0;
    logic                  empty;
    logic                  pop            = 1'b0;
    logic [HEIGHT_W-1:0]   height;

    int                    pending_heights;
    int                    fail_count;
    int                    cycle_count    = 0;
    int                    calm_left      = 0;
    int                    send_idle_pct  = 12;
    int                    recv_idle_pct  = 82;
    int                    items_sent     = 0;
    int unsigned           cur_w          = GRID_SIDE;
    int unsigned           cur_h          = GRID_SIDE;
    logic [TPU_W-1:0]      cur_tx         = TPU_RST;
    logic [TPU_W-1:0]      cur_tz         = TPU_RST;
    bit                    written_map [GRID_SIDE*GRID_SIDE];

    heightmap_bilinear_sampler_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .push           (push),
        .full           (full),
        .i_mode         (mode),
        .i_pos_x        (pos_x),
        .i_pos_z        (pos_z),
        .i_write_col    (write_col),
        .i_write_row    (write_row),
        .i_write_height (write_height),
        .empty          (empty),
        .pop            (pop),
        .o_height       (height)
    );

    heightmap_bilinear_sampler_core_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_push         (push),
        .i_full         (full),
        .i_mode         (mode),
        .i_pos_x        (pos_x),
        .i_pos_z        (pos_z),
        .i_write_col    (write_col),
        .i_write_row    (write_row),
        .i_write_height (write_height),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_height       (height),
        .o_pending      (pending_heights),
        .o_fail_count   (fail_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("heightmap_bilinear_sampler_core_test: FAIL");
            $finish;
        end
    end

    // occasional stretches where neither side idles
    always @(posedge clk) begin
        if (calm_left != 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(199) == 0)
            calm_left <= $urandom_range(60, 20);
    end

    always @(posedge clk) begin
        pop <= (calm_left != 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [31:0] random_pos();
        if ($urandom_range(4) == 0) return $urandom();
        return $signed($urandom()) >>> $urandom_range(31);
    endfunction

    function automatic logic [31:0] random_tpu();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(32'h0004_0000);
            2:       return TPU_RST;
            default: return $urandom_range(32'h0100_0000);
        endcase
    endfunction

    task automatic send_item(logic m, logic [31:0] x, logic [31:0] z,
                             logic [7:0] c, logic [7:0] r, logic [15:0] h);
        if (calm_left == 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge clk); while (calm_left == 0 && $urandom_range(99) < send_idle_pct);
        end
        push         <= 1'b1;
        mode         <= m;
        pos_x        <= x;
        pos_z        <= z;
        write_col    <= c;
        write_row    <= r;
        write_height <= h;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    task automatic send_write(logic [7:0] c, logic [7:0] r, logic [15:0] h);
        written_map[r*GRID_SIDE + c] = 1'b1;
        send_item(MODE_WRITE, random_pos(), random_pos(), c, r, h);
    endtask

    // fills any unwritten neighbour first, so the sample never reads junk
    task automatic sample_at(logic [31:0] x, logic [31:0] z);
        int unsigned ix;
        int unsigned iz;
        ix = grid_coord(x, cur_tx, cur_w) >> FRAC_BITS;
        iz = grid_coord(z, cur_tz, cur_h) >> FRAC_BITS;
        for (int dz = 0; dz < 2; dz++) begin
            for (int dx = 0; dx < 2; dx++) begin
                if (!written_map[(iz+dz)*GRID_SIDE + ix + dx])
                    send_write(8'(ix + dx), 8'(iz + dz), 16'($urandom()));
            end
        end
        send_item(MODE_SAMPLE, x, z, 8'($urandom()), 8'($urandom()), 16'($urandom()));
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_maps(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                            logic [31:0] tx, logic [31:0] tz);
        cfg_write(CFG_MAP_WIDTH,  {23'($urandom()), w});
        cfg_write(CFG_MAP_HEIGHT, {23'($urandom()), h});
        cfg_write(CFG_TPU_X, tx);
        cfg_write(CFG_TPU_Z, tz);
        cfg_valid <= 1'b0;
        cur_w  = eff_side(w);
        cur_h  = eff_side(h);
        cur_tx = tx;
        cur_tz = tz;
    endtask

    // writes give no result, so allow for writes still in flight
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (pending_heights != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int goal;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 256 x 256 map, one texel per unit
        send_write(8'd254, 8'd254, 16'hFFFF);
        send_write(8'd255, 8'd254, 16'hFFFF);
        send_write(8'd254, 8'd255, 16'h0000);
        send_write(8'd255, 8'd255, 16'h0000);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        sample_at(32'h007E_7FFF, 32'h007E_7FFF);
        sample_at(32'h007E_8000, 32'h0000_0000);
        send_write(8'd0, 8'd0, 16'h0000);
        send_write(8'd1, 8'd0, 16'hFFFF);
        send_write(8'd0, 8'd1, 16'hFFFF);
        send_write(8'd1, 8'd1, 16'h0000);
        sample_at(32'h8000_0000, 32'h8000_0000);
        sample_at(32'hFF7F_8000, 32'hFF7F_8000);
        sample_at(32'hFF7F_7FFF, 32'hFF7F_8001);
        sample_at(32'h0000_0000, 32'h0000_0000);
        sample_at(32'hFFFF_FFFF, 32'h0000_0001);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            case (phase / 2)
                0:       begin send_idle_pct = 12; recv_idle_pct = 82; end
                1:       begin send_idle_pct = 82; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (phase)
                0: set_maps(9'd2, 9'd2, TPU_RST, 32'h0000_8000);
                1: set_maps(9'd256, 9'd256, 32'hFFFF_FFFF, 32'h0000_0001);
                2: set_maps(9'd0, 9'd511, 32'h0000_0000, 32'h0002_0000);
                3: set_maps(9'd1, 9'd257, random_tpu(), random_tpu());
                default: set_maps(9'($urandom_range(511)), 9'($urandom_range(511)),
                                  random_tpu(), random_tpu());
            endcase
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(99) < 25)
                    send_write(8'($urandom()), 8'($urandom()), 16'($urandom()));
                else
                    sample_at(random_pos(), random_pos());
            end
        end
        drain();

        if (fail_count == 0)
            $display("heightmap_bilinear_sampler_core_test: PASS");
        else
            $display("heightmap_bilinear_sampler_core_test: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hbs_pkg.sv
rtl/hbs_fifo.sv
rtl/hbs_front.sv
rtl/hbs_back.sv
rtl/heightmap_bilinear_sampler_core.sv
test/heightmap_bilinear_sampler_core_checker.sv
test/heightmap_bilinear_sampler_core_test.sv
